@@ sv/nrf_pkg.sv @@
`timescale 1ns / 1ps
// ============================================================================
// nrf_pkg
// Shared types and constants for the nearest rectangle finder.
// ============================================================================
package nrf_pkg;

    localparam int MaxRectsDefault = 32;
    localparam int CoordW = 32;
    localparam int CountW = 6;
    localparam int IndexW = 5;
    localparam int EntryW = 4 * CoordW;

    // Coordinate differences need 34 bits, squares 68, roots 34.
    localparam int DiffW = 34;
    localparam int MagW = 34;
    localparam int SqW = 68;
    localparam int RootW = 34;
    localparam int DistW = 35;

    localparam logic CmdWrite = 1'b0;
    localparam logic CmdQuery = 1'b1;

    typedef struct packed {
        logic [IndexW-1:0]        entry_index;
        logic signed [CoordW-1:0] edge_left;
        logic signed [CoordW-1:0] edge_top;
        logic signed [CoordW-1:0] edge_right;
        logic signed [CoordW-1:0] edge_bottom;
    } write_req_t;

    // Item passed from the front part to the search engine.
    typedef struct packed {
        logic                     is_query;
        write_req_t               wr;
        logic signed [CoordW-1:0] point_x;
        logic signed [CoordW-1:0] point_y;
    } work_t;

endpackage

@@ sv/nrf_if.sv @@
`timescale 1ns / 1ps
// ============================================================================
// nrf_req_if / nrf_rsp_if
// Valid/ready channels for requests and results.
// ============================================================================
interface nrf_req_if;
    logic                     valid;
    logic                     ready;
    logic                     cmd;
    logic [4:0]               entry_index;
    logic signed [31:0]       edge_left;
    logic signed [31:0]       edge_top;
    logic signed [31:0]       edge_right;
    logic signed [31:0]       edge_bottom;
    logic signed [31:0]       point_x;
    logic signed [31:0]       point_y;
    modport source (output valid, cmd, entry_index, edge_left, edge_top, edge_right,
                    edge_bottom, point_x, point_y, input ready);
    modport sink (input valid, cmd, entry_index, edge_left, edge_top, edge_right,
                  edge_bottom, point_x, point_y, output ready);
endinterface

interface nrf_rsp_if;
    logic       valid;
    logic       ready;
    logic [4:0] nearest_index;
    modport source (output valid, nearest_index, input ready);
    modport sink (input valid, nearest_index, output ready);
endinterface

@@ sv/nrf_ram.sv @@
`timescale 1ns / 1ps
// ============================================================================
// nrf_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ============================================================================
module nrf_ram #(
    parameter int Width = 8,
    parameter int Depth = 32
) (
    input  logic                                             clk,
    input  logic                                             we,
    input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0]     waddr,
    input  logic [Width-1:0]                                 wdata,
    input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0]     raddr,
    output logic [Width-1:0]                                 rdata
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

@@ sv/nrf_front.sv @@
`timescale 1ns / 1ps
// ============================================================================
// nrf_front
// Accepts requests, classifies them and queues them for the search engine.
// ============================================================================
module nrf_front (
    input  logic           clk,
    input  logic           rst_n,
    nrf_req_if.sink        req,
    output nrf_pkg::work_t work,
    output logic           work_valid,
    input  logic           work_take
);
    import nrf_pkg::*;

    // Two-entry queue.
    work_t      q_reg [2];
    logic [1:0] cnt_reg;
    logic       rd_reg;
    work_t      in_w;
    logic       push;
    logic       pop;

    assign req.ready  = (cnt_reg != 2'd2);
    assign push       = req.valid && req.ready;
    assign work_valid = (cnt_reg != 2'd0);
    assign pop        = work_valid && work_take;
    assign work       = q_reg[rd_reg];

    always_comb
    begin
        in_w.is_query          = (req.cmd == CmdQuery);
        in_w.wr.entry_index    = req.entry_index;
        in_w.wr.edge_left      = req.edge_left;
        in_w.wr.edge_top       = req.edge_top;
        in_w.wr.edge_right     = req.edge_right;
        in_w.wr.edge_bottom    = req.edge_bottom;
        in_w.point_x           = req.point_x;
        in_w.point_y           = req.point_y;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
            rd_reg  <= 1'b0;
        end
        else
        begin
            if (push)
            begin
                q_reg[rd_reg ^ cnt_reg[0]] <= in_w;
            end
            if (pop)
            begin
                rd_reg <= ~rd_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule

@@ sv/nrf_isqrt.sv @@
`timescale 1ns / 1ps
// ============================================================================
// nrf_isqrt
// Sequential floor square root of dx^2 + dy^2, two radicand bits per cycle.
// ============================================================================
module nrf_isqrt (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [nrf_pkg::MagW-1:0]      mag_a,
    input  logic [nrf_pkg::MagW-1:0]      mag_b,
    output logic                          done,
    output logic [nrf_pkg::RootW-1:0]     root
);
    import nrf_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_SQA, S_SQB, S_ROOT} state_t;

    state_t             state_reg;
    logic [MagW-1:0]    b_reg;
    logic [SqW-1:0]     rad_reg;
    logic [RootW+1:0]   rem_reg;
    logic [RootW-1:0]   root_reg;
    logic [5:0]         step_reg;
    logic [SqW-1:0]     sq_w;
    logic [MagW-1:0]    sq_in;
    logic [RootW+1:0]   rem_sh;
    logic [RootW+1:0]   trial;

    // Each 34x34 square is split into four partial products.
    logic [MagW-1:0]    sq_hold;
    logic [1:0]         part_reg;
    logic [2*17-1:0]    pp;
    logic [16:0]        pa;
    logic [16:0]        pb;

    assign sq_in  = sq_hold;
    assign pa     = part_reg[1] ? sq_in[33:17] : sq_in[16:0];
    assign pb     = part_reg[0] ? sq_in[33:17] : sq_in[16:0];
    assign pp     = pa * pb;
    // Each upper half selected adds 17 to the weight of the partial product.
    assign sq_w   = {34'd0, pp} << ({6'd0, part_reg[1], 4'd0} + {10'd0, part_reg[1]}
                    + {6'd0, part_reg[0], 4'd0} + {10'd0, part_reg[0]});
    assign rem_sh = {rem_reg[RootW-1:0], rad_reg[SqW-1 -: 2]};
    assign trial  = {root_reg, 2'b01};
    assign root   = root_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done      <= 1'b0;
            part_reg  <= 2'd0;
            step_reg  <= 6'd0;
        end
        else
        begin
            done <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        sq_hold   <= mag_a;
                        b_reg     <= mag_b;
                        rad_reg   <= '0;
                        part_reg  <= 2'd0;
                        state_reg <= S_SQA;
                    end
                end
                S_SQA, S_SQB:
                begin
                    rad_reg  <= rad_reg + sq_w;
                    part_reg <= part_reg + 2'd1;
                    if (part_reg == 2'd3)
                    begin
                        sq_hold <= b_reg;
                        if (state_reg == S_SQA)
                        begin
                            state_reg <= S_SQB;
                        end
                        else
                        begin
                            rem_reg   <= '0;
                            root_reg  <= '0;
                            step_reg  <= 6'd0;
                            state_reg <= S_ROOT;
                        end
                    end
                end
                S_ROOT:
                begin
                    rad_reg <= {rad_reg[SqW-3:0], 2'b00};
                    if (rem_sh >= trial)
                    begin
                        rem_reg  <= rem_sh - trial;
                        root_reg <= {root_reg[RootW-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg  <= rem_sh;
                        root_reg <= {root_reg[RootW-2:0], 1'b0};
                    end
                    step_reg <= step_reg + 6'd1;
                    if (step_reg == 6'(RootW - 1))
                    begin
                        done      <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end
endmodule

@@ sv/nrf_engine.sv @@
`timescale 1ns / 1ps
// ============================================================================
// nrf_engine
// Back part: stores rectangles and runs the two-pass nearest search.
// ============================================================================
module nrf_engine #(
    parameter int MaxRects = nrf_pkg::MaxRectsDefault
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [nrf_pkg::CountW-1:0]    rect_count,
    input  nrf_pkg::work_t                work,
    input  logic                          work_valid,
    output logic                          work_take,
    nrf_rsp_if.source                     rsp
);
    import nrf_pkg::*;

    localparam int AddrW = (MaxRects > 1) ? $clog2(MaxRects) : 1;
    localparam int IdxW  = AddrW + 1;

    typedef enum logic [3:0] {
        S_IDLE, S_READ, S_CONT, S_DIST, S_PREP, S_SQRT_GO, S_SQRT_WAIT, S_NEXT, S_OUT
    } state_t;

    state_t                    state_reg;
    work_t                     cur_reg;
    logic [IdxW-1:0]           n_reg;
    logic [IdxW-1:0]           i_reg;
    logic                      pass2_reg;
    logic [DistW-1:0]          best_d_reg;
    logic [IdxW-1:0]           best_reg;
    logic [DistW-1:0]          d_reg;
    logic [2:0]                pt_reg;
    logic                      rsp_valid_reg;
    logic [IndexW-1:0]         rsp_idx_reg;

    logic                      we;
    logic [AddrW-1:0]          raddr;
    logic [EntryW-1:0]         rdata;

    logic signed [DiffW-1:0]   l, t, r, b, x, y, cx, cy, px, py;
    logic [MagW-1:0]           mag_a_reg, mag_b_reg;
    logic                      sq_start_reg;
    logic                      sq_done;
    logic [RootW-1:0]          sq_root;
    logic [DistW-1:0]          gap_min;
    logic [MagW-1:0]           g0, g1, g2, g3;
    logic                      in_x, in_y;
    logic [IdxW-1:0]           cnt_clip;

    assign we = (state_reg == S_IDLE) && work_valid && !work.is_query
                && (int'(work.wr.entry_index) < MaxRects);
    assign raddr = i_reg[AddrW-1:0];

    nrf_ram #(.Width(EntryW), .Depth(MaxRects)) u_table (
        .clk   (clk),
        .we    (we),
        .waddr (AddrW'(work.wr.entry_index)),
        .wdata ({work.wr.edge_left, work.wr.edge_top, work.wr.edge_right,
                 work.wr.edge_bottom}),
        .raddr (raddr),
        .rdata (rdata)
    );

    function automatic logic [MagW-1:0] mag(input logic signed [DiffW-1:0] v);
        logic signed [DiffW-1:0] n;
        begin
            n = -v;
            mag = v[DiffW-1] ? MagW'(n) : MagW'(v);
        end
    endfunction

    assign l  = DiffW'(signed'(rdata[127:96]));
    assign t  = DiffW'(signed'(rdata[95:64]));
    assign r  = DiffW'(signed'(rdata[63:32]));
    assign b  = DiffW'(signed'(rdata[31:0]));
    assign x  = DiffW'(cur_reg.point_x);
    assign y  = DiffW'(cur_reg.point_y);
    assign cx = l + DiffW'(mag(l - r) >> 1);
    assign cy = t + DiffW'(mag(t - b) >> 1);
    assign in_x = (x >= l) && (x <= r);
    assign in_y = (y >= t) && (y <= b);

    always_comb
    begin
        case (pt_reg)
            3'd0:    begin px = cx; py = cy; end
            3'd1:    begin px = l;  py = t;  end
            3'd2:    begin px = r;  py = t;  end
            3'd3:    begin px = r;  py = b;  end
            default: begin px = l;  py = b;  end
        endcase
    end

    assign g0 = in_x ? mag(t - y) : '1;
    assign g1 = in_x ? mag(b - y) : '1;
    assign g2 = in_y ? mag(l - x) : '1;
    assign g3 = in_y ? mag(r - x) : '1;

    always_comb
    begin
        gap_min = {1'b1, g0};
        if ({1'b0, g1} < gap_min) gap_min = {1'b0, g1};
        if ({1'b0, g2} < gap_min) gap_min = {1'b0, g2};
        if ({1'b0, g3} < gap_min) gap_min = {1'b0, g3};
        if (in_x && ({1'b0, g0} < gap_min)) gap_min = {1'b0, g0};
    end

    assign cnt_clip = (int'(rect_count) > MaxRects) ? IdxW'(MaxRects)
                                                    : IdxW'(rect_count);

    nrf_isqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sq_start_reg),
        .mag_a (mag_a_reg),
        .mag_b (mag_b_reg),
        .done  (sq_done),
        .root  (sq_root)
    );

    assign work_take         = (state_reg == S_IDLE) && work_valid
                               && (!work.is_query || !rsp_valid_reg);
    assign rsp.valid         = rsp_valid_reg;
    assign rsp.nearest_index = rsp_idx_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
            sq_start_reg  <= 1'b0;
            i_reg         <= '0;
            pass2_reg     <= 1'b0;
        end
        else
        begin
            sq_start_reg <= 1'b0;
            if (rsp_valid_reg && rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (work_take && work.is_query)
                    begin
                        cur_reg   <= work;
                        n_reg     <= cnt_clip;
                        i_reg     <= '0;
                        pass2_reg <= 1'b0;
                        best_reg  <= '0;
                        state_reg <= (cnt_clip == '0) ? S_OUT : S_READ;
                    end
                end
                S_READ:
                begin
                    state_reg <= pass2_reg ? S_DIST : S_CONT;
                end
                S_CONT:
                begin
                    if (in_x && in_y)
                    begin
                        best_reg  <= i_reg;
                        state_reg <= S_OUT;
                    end
                    else if (i_reg + 1'b1 == n_reg)
                    begin
                        i_reg     <= '0;
                        pass2_reg <= 1'b1;
                        state_reg <= S_READ;
                    end
                    else
                    begin
                        i_reg     <= i_reg + 1'b1;
                        state_reg <= S_READ;
                    end
                end
                S_DIST:
                begin
                    d_reg     <= gap_min;
                    pt_reg    <= 3'd0;
                    state_reg <= S_PREP;
                end
                S_PREP:
                begin
                    mag_a_reg    <= mag(px - x);
                    mag_b_reg    <= mag(py - y);
                    sq_start_reg <= 1'b1;
                    state_reg    <= S_SQRT_WAIT;
                end
                S_SQRT_WAIT:
                begin
                    if (sq_done)
                    begin
                        if ({1'b0, sq_root} < d_reg)
                        begin
                            d_reg <= {1'b0, sq_root};
                        end
                        if (pt_reg == 3'd4)
                        begin
                            state_reg <= S_NEXT;
                        end
                        else
                        begin
                            pt_reg    <= pt_reg + 3'd1;
                            state_reg <= S_PREP;
                        end
                    end
                end
                S_NEXT:
                begin
                    if ((i_reg == '0) || (d_reg < best_d_reg))
                    begin
                        best_d_reg <= d_reg;
                        best_reg   <= i_reg;
                    end
                    if (i_reg + 1'b1 == n_reg)
                    begin
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        i_reg     <= i_reg + 1'b1;
                        state_reg <= S_READ;
                    end
                end
                S_OUT:
                begin
                    rsp_valid_reg <= 1'b1;
                    rsp_idx_reg   <= IndexW'(best_reg);
                    state_reg     <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end
endmodule

@@ sv/nearest_rectangle_finder_top.sv @@
`timescale 1ns / 1ps
// ============================================================================
// nearest_rectangle_finder_top
// Rectangle table with containing-or-nearest point query.
// ============================================================================
// A write request stores one rectangle and produces no result. A query request
// first scans entries 0..N-1 (N entries in use) for one that contains the point,
// and if none does, scans them again computing five Euclidean distances each
// through one shared square-root unit. The square-root unit bounds the rate.
// A two-entry request queue and a result register let both sides stall
// independently; requests are handled one at a time. The user must write
// rect_count only while idle; the block itself does not enforce this.
module nearest_rectangle_finder_top #(
    parameter int MaxRects = nrf_pkg::MaxRectsDefault
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [nrf_pkg::CountW-1:0]   cfg_wdata,
    nrf_req_if.sink                      req,
    nrf_rsp_if.source                    rsp
);
    import nrf_pkg::*;

    logic [CountW-1:0] rect_count_reg;
    work_t             work;
    logic              work_valid;
    logic              work_take;

    // Configuration register holding the number of entries in use.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rect_count_reg <= '0;
        end
        else if (cfg_we)
        begin
            rect_count_reg <= cfg_wdata;
        end
    end

    // Front part: accepts and queues requests.
    nrf_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .work       (work),
        .work_valid (work_valid),
        .work_take  (work_take)
    );

    // Back part: table storage and search.
    nrf_engine #(.MaxRects(MaxRects)) u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .rect_count (rect_count_reg),
        .work       (work),
        .work_valid (work_valid),
        .work_take  (work_take),
        .rsp        (rsp)
    );
endmodule

@@ sv/nrf_checker.sv @@
`timescale 1ns / 1ps
// ============================================================================
// nrf_checker
// Port-level checks for the nearest rectangle finder.
// ============================================================================
module nrf_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       req_valid,
    input logic       req_ready,
    input logic       rsp_valid,
    input logic       rsp_ready,
    input logic [4:0] rsp_index
);
    // A result that is waiting holds its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_index))
        else $error("result changed while stalled");

    // The result never appears in the cycle after reset.
    assert property (@(posedge clk) $rose(rst_n) |-> !rsp_valid)
        else $error("result out of reset");

    // The request side keeps its ready until a request is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        req_ready && !req_valid |=> req_ready)
        else $error("ready dropped without a request");
endmodule

bind nearest_rectangle_finder_top nrf_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .rsp_index (rsp.nearest_index)
);
